>>> hdl/prc_pkg.sv
// Package with the item types, field widths, sequencer states and divider handshake types.
`default_nettype none
package prc_pkg;

  localparam int unsigned FIELD_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH = 13;
  localparam int unsigned SUM_WIDTH   = 28;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] range_low;
    logic [FIELD_WIDTH-1:0] range_high;
  } request_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] prime_count;
    logic [SUM_WIDTH-1:0]   prime_sum;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_CHECK,
    ST_DIV,
    ST_ADVANCE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic running;
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage
`default_nettype wire

>>> hdl/prc_mod_unit.sv
// Restoring remainder unit that finds dividend modulo divisor one bit per cycle.
`default_nettype none
module prc_mod_unit #(
  parameter int unsigned NUMBER_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire prc_pkg::div_ctl_t       ctl,
  input  wire logic [NUMBER_WIDTH-1:0] dividend,
  input  wire logic [NUMBER_WIDTH-1:0] divisor,
  output prc_pkg::div_stat_t           stat
);

  localparam int unsigned CW = $clog2(NUMBER_WIDTH);

  logic                    running;
  logic                    done;
  logic [CW-1:0]           cnt;
  logic [NUMBER_WIDTH-1:0] dvd;
  logic [NUMBER_WIDTH-1:0] dvs;
  logic [NUMBER_WIDTH-1:0] rem;
  logic [NUMBER_WIDTH:0]   trial;
  logic [NUMBER_WIDTH-1:0] rem_next;

  always_comb begin
    trial = {rem, dvd[NUMBER_WIDTH-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = NUMBER_WIDTH'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[NUMBER_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        cnt     <= CW'(NUMBER_WIDTH - 1);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[NUMBER_WIDTH-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign stat.running  = running;
  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule
`default_nettype wire

>>> hdl/prime_range_count_sum_top.sv
// Top level: sequencer that walks the range and counts and sums primes by trial division.
`default_nettype none
// Raise start with a range while busy is low; the block then walks every number from
// range_low to range_high and tests it by trial division with divisors d while d*d <= n.
// Each trial division runs through one shared remainder unit, and a composite stops at its
// smallest factor. The result appears on result for exactly one cycle with done high, and
// busy drops in the following cycle. The receiver cannot stall and must take it then.
module prime_range_count_sum_top #(
  parameter int unsigned NUMBER_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire prc_pkg::request_t request,
  output logic                   busy,
  output logic                   done,
  output prc_pkg::result_t       result
);

  localparam int unsigned NW = NUMBER_WIDTH;

  prc_pkg::state_t    state;
  prc_pkg::state_t    state_next;
  prc_pkg::div_ctl_t  div_ctl;
  prc_pkg::div_stat_t div_stat;

  logic [NW-1:0]                   lo_in;
  logic [NW-1:0]                   hi_in;
  logic [NW-1:0]                   n;
  logic [NW-1:0]                   hi;
  logic [NW-1:0]                   d;
  logic [NW:0]                     sq;
  logic [prc_pkg::COUNT_WIDTH-1:0] count;
  logic [prc_pkg::SUM_WIDTH-1:0]   sum;
  logic                            accept;
  logic                            sq_over;

  assign lo_in   = NW'(32'(request.range_low));
  assign hi_in   = NW'(32'(request.range_high));
  assign accept  = start && !busy;
  assign sq_over = sq > {1'b0, n};

  prc_mod_unit #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (n),
    .divisor  (d),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      prc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (lo_in > hi_in) ? prc_pkg::ST_FINISH : prc_pkg::ST_NEXT;
        end
      end
      prc_pkg::ST_NEXT: begin
        state_next = (n < NW'(2)) ? prc_pkg::ST_ADVANCE : prc_pkg::ST_CHECK;
      end
      prc_pkg::ST_CHECK: begin
        state_next = sq_over ? prc_pkg::ST_ADVANCE : prc_pkg::ST_DIV;
      end
      prc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = div_stat.rem_zero ? prc_pkg::ST_ADVANCE : prc_pkg::ST_CHECK;
        end
      end
      prc_pkg::ST_ADVANCE: begin
        state_next = (n == hi) ? prc_pkg::ST_FINISH : prc_pkg::ST_NEXT;
      end
      prc_pkg::ST_FINISH: begin
        state_next = prc_pkg::ST_IDLE;
      end
      default: begin
        state_next = prc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = (state != prc_pkg::ST_IDLE);
    done          = (state == prc_pkg::ST_FINISH);
    div_ctl.start = (state == prc_pkg::ST_CHECK) && !sq_over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      prc_pkg::ST_IDLE: begin
        if (start) begin
          n     <= lo_in;
          hi    <= hi_in;
          count <= '0;
          sum   <= '0;
        end
      end
      prc_pkg::ST_NEXT: begin
        d  <= NW'(2);
        sq <= (NW + 1)'(4);
      end
      prc_pkg::ST_CHECK: begin
        if (sq_over) begin
          count <= count + 1'b1;
          sum   <= sum + prc_pkg::SUM_WIDTH'(n);
        end
      end
      prc_pkg::ST_DIV: begin
        if (div_stat.done && !div_stat.rem_zero) begin
          d  <= d + 1'b1;
          sq <= sq + {d, 1'b1};
        end
      end
      prc_pkg::ST_ADVANCE: begin
        n <= n + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign result.prime_count = count;
  assign result.prime_sum   = sum;

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy still high after result");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.running |-> (state == prc_pkg::ST_DIV))
    else $error("remainder unit running outside its state");

  a_div_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_stat.running)
    else $error("remainder unit restarted while running");

endmodule
`default_nettype wire

>>> test/tb_prime_range_count_sum_top.sv
// Testbench that sends number ranges to the prime range counter and checks each count and sum.
`default_nettype none
module tb_prime_range_count_sum_top;

  localparam int unsigned FIELD_WIDTH = prc_pkg::FIELD_WIDTH;
  localparam int unsigned COUNT_WIDTH = prc_pkg::COUNT_WIDTH;
  localparam int unsigned SUM_WIDTH = prc_pkg::SUM_WIDTH;
  localparam int unsigned NUMBER_WIDTH = 16;
  localparam logic [63:0] NUMBER_MASK = (64'd1 << NUMBER_WIDTH) - 64'd1;
  localparam int unsigned STALL_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  prc_pkg::request_t request = '0;
  logic busy;
  logic done;
  prc_pkg::result_t result;

  prc_pkg::result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned ranges_checked = 0;
  int unsigned primes_total = 0;
  int unsigned widest_range = 0;
  int unsigned stall_cycles = 0;
  bit no_gaps = 1'b0;

  prime_range_count_sum_top #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic prc_pkg::result_t tally_primes(input logic [FIELD_WIDTH-1:0] lo_in,
                                                    input logic [FIELD_WIDTH-1:0] hi_in);
    prc_pkg::result_t tally;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] count;
    logic [63:0] sum;
    bit is_prime;
    lo = 64'(lo_in) & NUMBER_MASK;
    hi = 64'(hi_in) & NUMBER_MASK;
    count = '0;
    sum = '0;
    if (lo <= hi) begin
      for (n = lo; n <= hi; n++) begin
        is_prime = (n >= 64'd2);
        for (d = 64'd2; is_prime && d * d <= n; d++) begin
          if (n % d == 64'd0) begin
            is_prime = 1'b0;
          end
        end
        if (is_prime) begin
          count++;
          sum += n;
        end
      end
    end
    tally.prime_count = count[COUNT_WIDTH-1:0];
    tally.prime_sum = sum[SUM_WIDTH-1:0];
    return tally;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (no_gaps || roll < 35) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(4, 1);
    end else if (roll < 96) begin
      return $urandom_range(30, 5);
    end
    return $urandom_range(300, 50);
  endfunction

  // Start stays high from one item to the next when no gap is wanted.
  task automatic send_range(input logic [FIELD_WIDTH-1:0] lo, input logic [FIELD_WIDTH-1:0] hi);
    int unsigned gap;
    prc_pkg::result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= '{range_low: lo, range_high: hi};
    do @(posedge clk); while (busy);
    predicted = tally_primes(lo, hi);
    pending_results.push_back(predicted);
    ranges_checked++;
    primes_total += predicted.prime_count;
    if (lo <= hi && hi - lo + 1 > widest_range) begin
      widest_range = hi - lo + 1;
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    prc_pkg::result_t wanted;
    if (!rst) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item or result for %0d cycles", $time, STALL_LIMIT);
        $display("tb_prime_range_count_sum_top NOT OK");
        $finish;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: count %0d sum %0d", $time,
                   result.prime_count, result.prime_sum);
          error_count++;
        end else begin
          wanted = pending_results.pop_front();
          if (result.prime_count !== wanted.prime_count) begin
            $display("%0t: prime_count expected %0d got %0d", $time, wanted.prime_count,
                     result.prime_count);
            error_count++;
          end
          if (result.prime_sum !== wanted.prime_sum) begin
            $display("%0t: prime_sum expected %0d got %0d", $time, wanted.prime_sum,
                     result.prime_sum);
            error_count++;
          end
        end
      end
    end
  end

  task automatic test_smallest_numbers();
    send_range(16'd0, 16'd0);
    send_range(16'd0, 16'd1);
    send_range(16'd1, 16'd1);
    send_range(16'd2, 16'd2);
    send_range(16'd3, 16'd3);
    send_range(16'd4, 16'd4);
    send_range(16'd0, 16'd2);
    send_range(16'd0, 16'd30);
  endtask

  task automatic test_empty_ranges();
    send_range(16'd5, 16'd4);
    send_range(16'd1, 16'd0);
    send_range(16'hFFFF, 16'd0);
    send_range(16'hFFFF, 16'hFFFE);
  endtask

  task automatic test_field_extremes();
    send_range(16'hFFFF, 16'hFFFF);
    send_range(16'd65521, 16'd65521);
    send_range(16'd65521, 16'hFFFF);
    send_range(16'h8000, 16'h8010);
    send_range(16'd0, 16'd1000);
    send_range(16'hFF00, 16'hFFFF);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    send_range(16'd10, 16'd20);
    send_range(16'd97, 16'd97);
    send_range(16'd20, 16'd10);
    send_range(16'd1000, 16'd1010);
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_range(16'd100, 16'd120);
    send_range(16'd7919, 16'd7920);
    wait_all_results();
    send_range(16'd4093, 16'd4099);
  endtask

  task automatic test_random_ranges(input int unsigned item_total);
    logic [FIELD_WIDTH-1:0] lo;
    logic [FIELD_WIDTH-1:0] hi;
    int unsigned roll;
    for (int unsigned i = 0; i < item_total; i++) begin
      no_gaps = (i >= 40 && i < 55);
      roll = $urandom_range(99, 0);
      lo = FIELD_WIDTH'($urandom);
      if (roll < 60) begin
        hi = (lo > 16'hFFFF - 16'd12) ? 16'hFFFF : lo + FIELD_WIDTH'($urandom_range(12, 0));
      end else if (roll < 78) begin
        if (lo == 16'd0) begin
          lo = 16'd1;
        end
        hi = FIELD_WIDTH'($urandom_range(lo - 1, 0));
      end else if (roll < 93) begin
        lo = FIELD_WIDTH'($urandom_range(255, 0));
        hi = lo + FIELD_WIDTH'($urandom_range(64, 0));
      end else begin
        hi = FIELD_WIDTH'($urandom);
        lo = (hi < 16'd3) ? 16'd0 : hi - FIELD_WIDTH'($urandom_range(3, 0));
      end
      send_range(lo, hi);
      if (i % 25 == 24) begin
        wait_all_results();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_smallest_numbers();
    test_empty_ranges();
    test_field_extremes();
    test_back_to_back();
    test_drain_pause();
    test_random_ranges(75);
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d ranges holding %0d primes in total, widest range %0d numbers.",
             ranges_checked, primes_total, widest_range);
    $display("Ranges covered single numbers, empty ranges, the field limits and random spans.");
    if (error_count == 0) begin
      $display("tb_prime_range_count_sum_top OK");
    end else begin
      $display("tb_prime_range_count_sum_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hdl/prc_pkg.sv
hdl/prc_mod_unit.sv
hdl/prime_range_count_sum_top.sv
test/tb_prime_range_count_sum_top.sv
